[rtl/crlf_pkg.sv]
`timescale 1ns / 1ps

package crlf_pkg;

   // Width of the converted length and of the magnitude accumulator.
   localparam int NUMBER_WIDTH = 32;
   localparam int PROD_WIDTH   = NUMBER_WIDTH + 4;

   // Largest magnitude, 2**(NUMBER_WIDTH-1), at product width.
   localparam logic [PROD_WIDTH-1:0] MAG_LIMIT = PROD_WIDTH'(1) << (NUMBER_WIDTH - 1);

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_HT    = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_CMD  = 3'd0,
      PH_KLEN = 3'd1,
      PH_KEY  = 3'd2,
      PH_VLEN = 3'd3,
      PH_VAL  = 3'd4
   } line_phase_type;

   typedef enum logic [1:0] {
      CV_BLANK  = 2'd0,
      CV_DIGITS = 2'd1,
      CV_STOP   = 2'd2
   } conv_phase_type;

   typedef enum logic [1:0] {
      EV_TEXT = 2'd0,
      EV_LINE = 2'd1,
      EV_FAIL = 2'd2
   } event_type;

   typedef struct packed {
      event_type                 event_res;
      logic [2:0]                field;
      logic [7:0]                text_byte;
      logic [NUMBER_WIDTH-1:0]   number;
      logic                      request_done;
   } rsp_type;

endpackage

[rtl/crlf_request_line_parser.sv]
`timescale 1ns / 1ps

// CR LF request line parser.
// The input channel (req_valid, req_stall, req_data_byte) takes one request
// byte per item. A request is five lines, each ended by CR LF: command, key
// length, key, value length and value. Each command, key or value byte gives
// one result item tagged with its field; each completed line gives a line
// item, carrying the converted number for the two length lines and
// request_done for the value line. A zero byte or an LF without a prior CR
// gives a fail item and the parser restarts at the command line.
// The state update for a byte happens in the cycle it is accepted, so one
// byte is taken every cycle while req_stall is low. A result is registered
// in the output register behind the rsp_ ports. When the receiver raises
// rsp_stall, the shown item holds and one more result is caught in a skid
// register; req_stall rises only then and falls once the skid drains.
// Reset is synchronous and returns the parser to the start of the command
// line with both output registers empty.
module crlf_request_line_parser
   import crlf_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_event_res,
   output logic [2:0]                     rsp_field,
   output logic [7:0]                     rsp_text_byte,
   output logic signed [NUMBER_WIDTH-1:0] rsp_number,
   output logic                           rsp_request_done
);

   line_phase_type            line_phase_ff, line_phase_in;
   logic                      cr_seen_ff, cr_seen_in;
   conv_phase_type            conv_phase_ff, conv_phase_in;
   logic                      negative_ff, negative_in;
   logic [NUMBER_WIDTH-1:0]   accum_ff, accum_in;

   logic                      out_valid_ff, out_valid_in;
   rsp_type                   out_ff, out_in;
   logic                      skid_valid_ff, skid_valid_in;
   rsp_type                   skid_ff, skid_in;

   logic                      accept;
   logic                      res_valid;
   rsp_type                   res;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   always_comb begin
      logic [7:0]              c;
      logic                    is_len;
      logic                    is_blank;
      logic                    is_digit;
      conv_phase_type          cv;
      logic [PROD_WIDTH-1:0]   prod;
      logic [NUMBER_WIDTH-1:0] conv_value;
      line_phase_type          ph_next;

      c        = req_data_byte;
      is_len   = (line_phase_ff == PH_KLEN) || (line_phase_ff == PH_VLEN);
      is_blank = (c == CHAR_SPACE) || (c == CHAR_HT) || (c == CHAR_VT) || (c == CHAR_FF);
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      prod     = {accum_ff, 3'b000} + {2'b00, accum_ff, 1'b0}
                 + {{(PROD_WIDTH-4){1'b0}}, c[3:0]};
      cv       = conv_phase_ff;

      if (negative_ff) begin
         conv_value = NUMBER_WIDTH'(0) - accum_ff;
      end else if ({4'b0000, accum_ff} > MAG_LIMIT - PROD_WIDTH'(1)) begin
         conv_value = NUMBER_WIDTH'(MAG_LIMIT - PROD_WIDTH'(1));
      end else begin
         conv_value = accum_ff;
      end

      unique case (line_phase_ff)
         PH_CMD:  ph_next = PH_KLEN;
         PH_KLEN: ph_next = PH_KEY;
         PH_KEY:  ph_next = PH_VLEN;
         PH_VLEN: ph_next = PH_VAL;
         PH_VAL:  ph_next = PH_CMD;
         default: ph_next = PH_KLEN;
      endcase

      line_phase_in = line_phase_ff;
      cr_seen_in    = cr_seen_ff;
      conv_phase_in = conv_phase_ff;
      negative_in   = negative_ff;
      accum_in      = accum_ff;

      res_valid        = 1'b0;
      res.event_res    = EV_TEXT;
      res.field        = line_phase_ff;
      res.text_byte    = 8'h00;
      res.number       = '0;
      res.request_done = 1'b0;

      if (accept) begin
         if ((c == CHAR_NUL) || ((c == CHAR_LF) && !cr_seen_ff)) begin
            res_valid     = 1'b1;
            res.event_res = EV_FAIL;
            line_phase_in = PH_CMD;
            cr_seen_in    = 1'b0;
            conv_phase_in = CV_BLANK;
            negative_in   = 1'b0;
            accum_in      = '0;
         end else if (c == CHAR_CR) begin
            cr_seen_in = 1'b1;
         end else if (c == CHAR_LF) begin
            res_valid        = 1'b1;
            res.event_res    = EV_LINE;
            res.number       = is_len ? conv_value : '0;
            res.request_done = (line_phase_ff == PH_VAL);
            line_phase_in    = ph_next;
            cr_seen_in       = 1'b0;
            conv_phase_in    = CV_BLANK;
            negative_in      = 1'b0;
            accum_in         = '0;
         end else if (is_len) begin
            // A non-blank, non-sign byte ends the blank phase and is then
            // judged as a digit in the same step.
            if (cv == CV_BLANK) begin
               if (is_blank) begin
                  cv = CV_BLANK;
               end else if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
                  negative_in = (c == CHAR_MINUS);
                  cv          = CV_STOP;
                  conv_phase_in = CV_DIGITS;
               end else begin
                  cv            = CV_DIGITS;
                  conv_phase_in = CV_DIGITS;
               end
            end
            if (cv == CV_DIGITS) begin
               if (is_digit) begin
                  accum_in = (prod > MAG_LIMIT) ? NUMBER_WIDTH'(MAG_LIMIT)
                                                : NUMBER_WIDTH'(prod);
               end else begin
                  conv_phase_in = CV_STOP;
               end
            end
         end else begin
            res_valid     = 1'b1;
            res.text_byte = c;
            if ((line_phase_ff != PH_KEY) && (line_phase_ff != PH_VAL)) begin
               line_phase_in = PH_CMD;
            end
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && rsp_stall) begin
         if (res_valid) begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end else begin
         out_valid_in = res_valid;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_phase_ff <= PH_CMD;
         cr_seen_ff    <= 1'b0;
         conv_phase_ff <= CV_BLANK;
         negative_ff   <= 1'b0;
         accum_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         line_phase_ff <= line_phase_in;
         cr_seen_ff    <= cr_seen_in;
         conv_phase_ff <= conv_phase_in;
         negative_ff   <= negative_in;
         accum_ff      <= accum_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_res    = out_ff.event_res;
   assign rsp_field        = out_ff.field;
   assign rsp_text_byte    = out_ff.text_byte;
   assign rsp_number       = out_ff.number;
   assign rsp_request_done = out_ff.request_done;

endmodule

[sim/tb_crlf_request_line_parser.sv]
`timescale 1ns / 1ps

module tb_crlf_request_line_parser
   import crlf_pkg::*;
();

   localparam int ITEMS_PER_PHASE = 450;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 16;

   typedef struct packed {
      logic [7:0] data;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [7:0]                     req_data_byte;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [1:0]                     rsp_event_res;
   logic [2:0]                     rsp_field;
   logic [7:0]                     rsp_text_byte;
   logic signed [NUMBER_WIDTH-1:0] rsp_number;
   logic                           rsp_request_done;

   // Parser state as the byte stream leaves it.
   line_phase_type    cur_line;
   logic              cr_flag;
   conv_phase_type    cur_conv;
   logic              neg_len;
   longint unsigned   magnitude;

   rsp_type           pending_results[$];
   rsp_type           oldest;
   int                mismatch_count;
   int                sent_count;
   int                cycle_count;
   int                send_idle;
   int                recv_idle;

   // A bare LF and a zero byte fail the request; a CR LF ends each line.
   // The length line fills ten nines after a minus sign, so it saturates.
   stim_row_type directed_rows [0:25] = '{
      '{CHAR_NUL,   1'b1, '{EV_FAIL, PH_CMD,  8'h00, 32'h0000_0000, 1'b0}},
      '{CHAR_LF,    1'b1, '{EV_FAIL, PH_CMD,  8'h00, 32'h0000_0000, 1'b0}},
      '{8'hFF,      1'b1, '{EV_TEXT, PH_CMD,  8'hFF, 32'h0000_0000, 1'b0}},
      '{CHAR_CR,    1'b0, '0},
      '{CHAR_LF,    1'b1, '{EV_LINE, PH_CMD,  8'h00, 32'h0000_0000, 1'b0}},
      '{CHAR_SPACE, 1'b0, '0},
      '{CHAR_MINUS, 1'b0, '0},
      '{CHAR_NINE,  1'b0, '0},
      '{CHAR_NINE,  1'b0, '0},
      '{CHAR_NINE,  1'b0, '0},
      '{CHAR_NINE,  1'b0, '0},
      '{CHAR_NINE,  1'b0, '0},
      '{CHAR_NINE,  1'b0, '0},
      '{CHAR_NINE,  1'b0, '0},
      '{CHAR_NINE,  1'b0, '0},
      '{CHAR_NINE,  1'b0, '0},
      '{CHAR_NINE,  1'b0, '0},
      '{CHAR_CR,    1'b0, '0},
      '{CHAR_LF,    1'b1, '{EV_LINE, PH_KLEN, 8'h00, 32'h8000_0000, 1'b0}},
      '{8'h80,      1'b0, '0},
      '{CHAR_CR,    1'b0, '0},
      '{8'h01,      1'b0, '0},
      '{CHAR_LF,    1'b1, '{EV_LINE, PH_KEY,  8'h00, 32'h0000_0000, 1'b0}},
      '{CHAR_CR,    1'b0, '0},
      '{CHAR_LF,    1'b1, '{EV_LINE, PH_VLEN, 8'h00, 32'h0000_0000, 1'b0}},
      '{CHAR_NUL,   1'b1, '{EV_FAIL, PH_VAL,  8'h00, 32'h0000_0000, 1'b0}}
   };

   crlf_request_line_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_field        (rsp_field),
      .rsp_text_byte    (rsp_text_byte),
      .rsp_number       (rsp_number),
      .rsp_request_done (rsp_request_done)
   );

   always #1 clock = ~clock;

   // Advances the parser state by one byte and returns whether it gives a result.
   function automatic bit parse_byte(input logic [7:0] b, output rsp_type r);
      longint unsigned lim;
      longint unsigned d;
      lim = 64'd1 << (NUMBER_WIDTH - 1);
      r = '0;
      r.event_res = EV_TEXT;
      r.field = cur_line;
      if (b == CHAR_NUL || (b == CHAR_LF && !cr_flag)) begin
         r.event_res = EV_FAIL;
         cur_line = PH_CMD;
         cr_flag = 1'b0;
         cur_conv = CV_BLANK;
         neg_len = 1'b0;
         magnitude = 0;
         return 1'b1;
      end
      if (b == CHAR_CR) begin
         cr_flag = 1'b1;
         return 1'b0;
      end
      if (b == CHAR_LF) begin
         r.event_res = EV_LINE;
         if (cur_line == PH_KLEN || cur_line == PH_VLEN) begin
            if (neg_len)
               r.number = NUMBER_WIDTH'(64'd0 - magnitude);
            else if (magnitude > lim - 1)
               r.number = NUMBER_WIDTH'(lim - 1);
            else
               r.number = NUMBER_WIDTH'(magnitude);
         end
         r.request_done = (cur_line == PH_VAL);
         cur_line = (cur_line == PH_VAL) ? PH_CMD : line_phase_type'(cur_line + 3'd1);
         cr_flag = 1'b0;
         cur_conv = CV_BLANK;
         neg_len = 1'b0;
         magnitude = 0;
         return 1'b1;
      end
      if (cur_line == PH_KLEN || cur_line == PH_VLEN) begin
         if (cur_conv == CV_BLANK) begin
            if (b == CHAR_SPACE || b == CHAR_HT || b == CHAR_VT || b == CHAR_FF)
               return 1'b0;
            cur_conv = CV_DIGITS;
            if (b == CHAR_MINUS || b == CHAR_PLUS) begin
               neg_len = (b == CHAR_MINUS);
               return 1'b0;
            end
         end
         if (cur_conv == CV_DIGITS) begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               d = longint'(b - CHAR_ZERO);
               if (magnitude > (lim - d) / 10)
                  magnitude = lim;
               else
                  magnitude = magnitude * 10 + d;
            end else begin
               cur_conv = CV_STOP;
            end
         end
         return 1'b0;
      end
      r.text_byte = b;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      mismatch_count++;
   endtask

   // A typed row pushes its written-out result; the parser state still advances.
   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input rsp_type want = '0);
      rsp_type r;
      bit has_result;
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_count++;
      has_result = parse_byte(b, r);
      if (typed)
         pending_results.push_back(want);
      else if (has_result)
         pending_results.push_back(r);
   endtask

   function automatic logic [7:0] rand_text();
      logic [7:0] r;
      do
         r = 8'($urandom_range(1, 255));
      while (r == CHAR_CR || r == CHAR_LF);
      return r;
   endfunction

   task automatic send_line(input bit is_length, output bit broken);
      string digits;
      longint unsigned v;
      int n;
      broken = 1'b0;
      if (is_length) begin
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
               0: send_byte(CHAR_SPACE);
               1: send_byte(CHAR_HT);
               2: send_byte(CHAR_VT);
               default: send_byte(CHAR_FF);
            endcase
         end
         case ($urandom_range(0, 3))
            1: send_byte(CHAR_PLUS);
            2: send_byte(CHAR_MINUS);
            default: ;
         endcase
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
               0: v = 64'd2147483647;
               1: v = 64'd2147483648;
               2: v = 64'd2147483649;
               3: v = 64'd0;
               default: v = longint'($urandom);
            endcase
            digits = $sformatf("%0d", v);
         end else begin
            digits = "";
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
            repeat (n)
               digits = {digits, string'(8'(CHAR_ZERO + $urandom_range(0, 9)))};
         end
         for (int i = 0; i < digits.len(); i++)
            send_byte(digits[i]);
         // A stray byte stops the conversion unless the converter can still take it; a digit after it is then ignored.
         if ($urandom_range(0, 4) == 0) begin
            send_byte(rand_text());
            if ($urandom_range(0, 1) == 0)
               send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
      end else begin
         repeat ($urandom_range(0, 6))
            send_byte(rand_text());
      end
      if ($urandom_range(0, 24) == 0) begin
         send_byte(($urandom_range(0, 1) == 0) ? CHAR_NUL : CHAR_LF);
         broken = 1'b1;
         return;
      end
      send_byte(CHAR_CR);
      // Bytes after the CR still belong to the line.
      if ($urandom_range(0, 9) == 0)
         send_byte(rand_text());
      send_byte(CHAR_LF);
   endtask

   task automatic send_request();
      bit broken;
      for (int i = 0; i < 5; i++) begin
         send_line(i == 1 || i == 3, broken);
         if (broken)
            return;
      end
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", 64'({rsp_event_res, rsp_field}), 64'd0);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_event_res != oldest.event_res)
               report_mismatch("event", 64'(rsp_event_res), 64'(oldest.event_res));
            if (rsp_field != oldest.field)
               report_mismatch("field", 64'(rsp_field), 64'(oldest.field));
            if (rsp_text_byte != oldest.text_byte)
               report_mismatch("text byte", 64'(rsp_text_byte), 64'(oldest.text_byte));
            if (rsp_number != oldest.number)
               report_mismatch("number", 64'(rsp_number), 64'(oldest.number));
            if (rsp_request_done != oldest.request_done)
               report_mismatch("request done", 64'(rsp_request_done),
                               64'(oldest.request_done));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("crlf_request_line_parser test failed");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      sent_count = 0;
      send_idle = 32;
      recv_idle = 53;
      cur_line = PH_CMD;
      cr_flag = 1'b0;
      cur_conv = CV_BLANK;
      neg_len = 1'b0;
      magnitude = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle = 32; recv_idle = 53; end
            1: begin send_idle = 53; recv_idle = 32; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         while (sent_count < (phase + 1) * ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 4))
                  send_byte(8'($urandom_range(0, 255)));
            end else begin
               send_request();
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("crlf_request_line_parser test passed");
      else
         $display("crlf_request_line_parser test failed");
      $finish;
   end

endmodule

[crlf_request_line_parser.f]
rtl/crlf_pkg.sv
rtl/crlf_request_line_parser.sv
sim/tb_crlf_request_line_parser.sv
